/* rtl/core/mic_gain_gate_dual_smoother_assert.svh */
// ----------------------------------------------------------------------------
// mic gain gate assertion macros
// shared assertion forms clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef MIC_GAIN_GATE_DUAL_SMOOTHER_ASSERT_SVH
`define MIC_GAIN_GATE_DUAL_SMOOTHER_ASSERT_SVH

// same-cycle implication
`define MGG_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MGG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/mgg_pkg.sv */
// ----------------------------------------------------------------------------
// mgg_pkg
// widths, register codes and the shared multiplier request for the level follower
// ----------------------------------------------------------------------------
package mgg_pkg;

	localparam int SAMPLE_SHIFT_DEF = 14;

	localparam int IN_W       = 32;
	localparam int SMP_W      = 22;
	localparam int GAIN_W     = 16;
	localparam int THR_W      = 22;
	localparam int ALPHA_W    = 16;
	localparam int CFG_W      = 22;
	localparam int CFG_IDX_W  = 2;
	localparam int GAIN_FRAC  = 12;
	localparam int ALPHA_FRAC = 16;

	// shared multiplier: signed a times unsigned b
	localparam int MUL_A_W = IN_W + 1;
	localparam int MUL_B_W = 16;
	localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

	localparam logic [GAIN_W-1:0]  GAIN_RST   = GAIN_W'(819);
	localparam logic [THR_W-1:0]   THR_RST    = THR_W'(50);
	localparam logic [ALPHA_W-1:0] ALPHA1_RST = ALPHA_W'(2621);
	localparam logic [ALPHA_W-1:0] ALPHA2_RST = ALPHA_W'(1966);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN   = 2'd0,
		REG_GATE   = 2'd1,
		REG_ALPHA1 = 2'd2,
		REG_ALPHA2 = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                      en;
		logic signed [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0]        b;
	} mul_req_t;

endpackage

/* rtl/core/mgg_mul.sv */
// ----------------------------------------------------------------------------
// mgg_mul
// shared signed-by-unsigned multiplier with a registered product
// ----------------------------------------------------------------------------
module mgg_mul
	import mgg_pkg::*;
(
	input  logic                     clk,
	input  mul_req_t                 req,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	// product register holds until the next issued multiply
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= PROD_W'(req.a) * $signed({1'b0, req.b});
		end
	end

	assign prod = prod_q;

endmodule

/* rtl/core/mic_gain_gate_dual_smoother.sv */
// ----------------------------------------------------------------------------
// mic_gain_gate_dual_smoother
// sequence: gain multiply, scale, then a multiply and an update for each smoother, then done
// one beat at a time: three passes through one multiplier before the next is taken
// in_ready is high only in idle; a waiting result holds the next level in done
// reset: async active low, registers back to defaults, both levels cleared
// ----------------------------------------------------------------------------
`include "mic_gain_gate_dual_smoother_assert.svh"

module mic_gain_gate_dual_smoother
	import mgg_pkg::*;
#(
	parameter int SAMPLE_SHIFT = SAMPLE_SHIFT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// register write port
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	// input beats
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [IN_W-1:0]  raw_word,
	// result beats
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [SMP_W-1:0] smoothed_level
);

	// width of the pre-scaled sample after the arithmetic shift
	localparam int XW = IN_W - SAMPLE_SHIFT;

	localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(2 ** (SMP_W - 1) - 1);
	localparam logic signed [PROD_W-1:0] SAT_LO = ~SAT_HI;

	// sequencer: three multiplies, gain first, then each smoother
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MULG  = 8'b0000_0010,
		ST_SCALE = 8'b0000_0100,
		ST_MUL1  = 8'b0000_1000,
		ST_UPD1  = 8'b0001_0000,
		ST_MUL2  = 8'b0010_0000,
		ST_UPD2  = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t                    state_q;
	logic [GAIN_W-1:0]         gain_q;
	logic [THR_W-1:0]          thr_q;
	logic [ALPHA_W-1:0]        alpha1_q;
	logic [ALPHA_W-1:0]        alpha2_q;
	logic signed [XW-1:0]      x_q;
	logic signed [SMP_W-1:0]   target_q;
	logic signed [SMP_W-1:0]   first_q;
	logic signed [SMP_W-1:0]   second_q;
	logic                      out_valid_q;
	logic signed [SMP_W-1:0]   out_q;

	mul_req_t                  mul_req;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  gain_rnd;
	logic signed [PROD_W-1:0]  scaled;
	logic signed [SMP_W-1:0]   sat_s;
	logic [SMP_W:0]            mag;
	logic signed [SMP_W-1:0]   gated;
	logic signed [SMP_W:0]     diff1;
	logic signed [SMP_W:0]     diff2;
	logic                      out_free;

	// prev + alpha*(target-prev), sum truncated toward zero
	function automatic logic signed [SMP_W-1:0] smooth_next(
		input logic signed [SMP_W-1:0]  prev,
		input logic signed [PROD_W-1:0] p
	);
		logic signed [PROD_W-1:0] num;
		logic signed [PROD_W-1:0] num_rnd;
		logic signed [PROD_W-1:0] shifted;
		num = $signed({{(PROD_W - SMP_W - ALPHA_FRAC){prev[SMP_W-1]}}, prev,
			{ALPHA_FRAC{1'b0}}}) + p;
		num_rnd = num + $signed({{(PROD_W - ALPHA_FRAC){1'b0}},
			{ALPHA_FRAC{num[PROD_W-1]}}});
		shifted = num_rnd >>> ALPHA_FRAC;
		return shifted[SMP_W-1:0];
	endfunction

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RST;
			thr_q    <= THR_RST;
			alpha1_q <= ALPHA1_RST;
			alpha2_q <= ALPHA2_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
				REG_GATE:   thr_q    <= cfg_data[THR_W-1:0];
				REG_ALPHA1: alpha1_q <= cfg_data[ALPHA_W-1:0];
				REG_ALPHA2: alpha2_q <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- shared multiplier
	// differences are one bit wider than a level so they never wrap
	assign diff1 = {target_q[SMP_W-1], target_q} - {first_q[SMP_W-1], first_q};
	assign diff2 = {first_q[SMP_W-1], first_q} - {second_q[SMP_W-1], second_q};

	always_comb begin
		mul_req = '0;
		case (state_q)
			ST_MULG: begin
				mul_req.en = 1'b1;
				mul_req.a  = {{(MUL_A_W - XW){x_q[XW-1]}}, x_q};
				mul_req.b  = gain_q;
			end
			ST_MUL1: begin
				mul_req.en = 1'b1;
				mul_req.a  = {{(MUL_A_W - SMP_W - 1){diff1[SMP_W]}}, diff1};
				mul_req.b  = alpha1_q;
			end
			ST_MUL2: begin
				mul_req.en = 1'b1;
				mul_req.a  = {{(MUL_A_W - SMP_W - 1){diff2[SMP_W]}}, diff2};
				mul_req.b  = alpha2_q;
			end
			default: ;
		endcase
	end

	mgg_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	// ---------------------------------------------------------------- gain, saturate, gate
	// product of the unsigned Q4.12 gain back to integer, truncated toward zero
	assign gain_rnd = prod + $signed({{(PROD_W - GAIN_FRAC){1'b0}},
		{GAIN_FRAC{prod[PROD_W-1]}}});
	assign scaled = gain_rnd >>> GAIN_FRAC;

	always_comb begin
		if (scaled > SAT_HI) begin
			sat_s = SAT_HI[SMP_W-1:0];
		end else if (scaled < SAT_LO) begin
			sat_s = SAT_LO[SMP_W-1:0];
		end else begin
			sat_s = scaled[SMP_W-1:0];
		end
	end

	// magnitude needs one extra bit for the most negative sample
	assign mag   = sat_s[SMP_W-1] ? ((SMP_W + 1)'(0) - {1'b1, sat_s}) : {1'b0, sat_s};
	// strict compare: a magnitude equal to the threshold passes
	assign gated = (mag < {1'b0, thr_q}) ? '0 : sat_s;

	// ---------------------------------------------------------------- sequencer
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			first_q  <= '0;
			second_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MULG;
					end
				end
				ST_MULG:  state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_MUL1;
				ST_MUL1:  state_q <= ST_UPD1;
				ST_UPD1: begin
					first_q <= smooth_next(first_q, prod);
					state_q <= ST_MUL2;
				end
				ST_MUL2:  state_q <= ST_UPD2;
				ST_UPD2: begin
					second_q <= smooth_next(second_q, prod);
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					// hold here until the result register can take the new level
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sample and target registers carry payload only
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_q <= XW'(raw_word >>> SAMPLE_SHIFT);
		end
		if (state_q == ST_SCALE) begin
			target_q <= gated;
		end
	end

	// ---------------------------------------------------------------- result register
	// separate from the sequencer so a new beat can enter while this one waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q <= second_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign smoothed_level = out_q;

	// ---------------------------------------------------------------- checks
	`MGG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted a beat mid-item")
	`MGG_ASSERT_NEXT(a_result_load, state_q == ST_DONE && out_free, out_valid_q && out_q == $past(second_q), "result register missed the new level")
	`MGG_ASSERT_IMPL(a_first_update, first_q != $past(first_q), $past(state_q) == ST_UPD1, "first level changed outside its update step")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for mic_gain_gate_dual_smoother
// drives raw microphone words through the gain stage, noise gate and both
// smoothers, predicts every smoothed level in a local model and checks each
// result beat in order; register settings change between drained phases
// ----------------------------------------------------------------------------
module testbench
	import mgg_pkg::*;
();

	localparam int  CLK_HALF    = 10;
	localparam int  RESET_CYC   = 6;
	localparam int  CYCLE_LIMIT = 400000;
	localparam int  SETTLE_CYC  = 12;
	localparam int  SHIFT       = SAMPLE_SHIFT_DEF;
	localparam longint SMP_MAX  = 2097151;
	localparam longint SMP_MIN  = -2097152;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [IN_W-1:0]  raw_word;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [SMP_W-1:0] smoothed_level;

	// local copy of the registers and both smoother levels
	logic [GAIN_W-1:0]  cur_gain;
	logic [THR_W-1:0]   cur_threshold;
	logic [ALPHA_W-1:0] cur_alpha1;
	logic [ALPHA_W-1:0] cur_alpha2;
	longint             lvl_first;
	longint             lvl_second;

	// smoothed levels waiting for their result beat
	logic signed [SMP_W-1:0] expected_levels[$];

	int  mismatch_count;
	int  result_count;
	int  cycle_count;
	bit  sender_gaps;
	bit  sink_gaps;
	int  hold_len;

	mic_gain_gate_dual_smoother i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.raw_word       (raw_word),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.smoothed_level (smoothed_level)
	);

	// free-running clock
	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// watchdog: a correct run ends far below this count
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------

	// one exponential smoother step, sum formed exactly then truncated toward zero
	function automatic longint smooth_step(longint prev, longint target, logic [ALPHA_W-1:0] a);
		longint alpha;
		alpha = a;
		return (prev * 65536 + alpha * (target - prev)) / 65536;
	endfunction

	// gain, gate and both smoothers for one raw word; advances the local levels
	function automatic logic signed [SMP_W-1:0] follow_level(logic signed [IN_W-1:0] raw);
		longint shifted;
		longint scaled;
		longint mag;
		longint g;
		longint thr;
		g       = cur_gain;
		thr     = cur_threshold;
		shifted = longint'(raw) >>> SHIFT;
		// signed divide truncates toward zero, as the gain stage does
		scaled  = (shifted * g) / 4096;
		if (scaled > SMP_MAX)
			scaled = SMP_MAX;
		if (scaled < SMP_MIN)
			scaled = SMP_MIN;
		mag = (scaled < 0) ? -scaled : scaled;
		// strict compare: a magnitude equal to the threshold passes
		if (mag < thr)
			scaled = 0;
		lvl_first  = smooth_step(lvl_first, scaled, cur_alpha1);
		lvl_second = smooth_step(lvl_second, lvl_first, cur_alpha2);
		return lvl_second[SMP_W-1:0];
	endfunction

	// raw word whose shifted sample is x, with random bits below the shift
	function automatic logic signed [IN_W-1:0] word_for_sample(longint x);
		longint low;
		low = $urandom_range(0, (1 << SHIFT) - 1);
		return IN_W'(x * (longint'(1) << SHIFT) + low);
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ------------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------------

	// receiver: random stalls, plus a long hold-off on request
	initial begin : sink
		int gap;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_len = 0;
				out_ready <= 1'b1;
			end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
				gap = pick_gap();
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// checker: each result beat against the oldest predicted level
	always @(posedge clk) begin : check_results
		logic signed [SMP_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			if (expected_levels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result beat %0d with nothing expected: got %0d",
						result_count, smoothed_level);
			end else begin
				want = expected_levels.pop_front();
				if (smoothed_level !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result beat %0d smoothed_level: expected %0d, got %0d",
							result_count, want, smoothed_level);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// input side and register port
	// ------------------------------------------------------------------------

	// offer one raw word, wait for its beat, predict its level
	task automatic send_beat(logic signed [IN_W-1:0] raw);
		int gap;
		gap = sender_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		raw_word <= raw;
		do
			@(posedge clk);
		while (!in_ready);
		expected_levels.push_back(follow_level(raw));
	endtask

	// stop offering and let every expected level arrive
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		// the block is idle again well within this
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// one register write; bits above the register width are dropped
	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_GAIN:   cur_gain      = data[GAIN_W-1:0];
			REG_GATE:   cur_threshold = data[THR_W-1:0];
			REG_ALPHA1: cur_alpha1    = data[ALPHA_W-1:0];
			REG_ALPHA2: cur_alpha2    = data[ALPHA_W-1:0];
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset values: full-scale words, zero and the smallest words
	task automatic test_reset_defaults();
		send_beat(32'sh7FFFFFFF);
		send_beat(32'sh80000000);
		send_beat(32'sh00000000);
		send_beat(-32'sd1);
		send_beat(32'sd1);
		drain();
	endtask

	// unity gain, the gate passes a magnitude equal to the threshold only
	task automatic test_gate_boundary();
		write_reg(REG_GAIN, GAIN_W'(4096));
		write_reg(REG_GATE, THR_W'(1000));
		write_reg(REG_ALPHA1, ALPHA_W'(65535));
		write_reg(REG_ALPHA2, ALPHA_W'(65535));
		send_beat(word_for_sample(1000));
		send_beat(word_for_sample(999));
		send_beat(word_for_sample(-1000));
		send_beat(word_for_sample(-999));
		drain();
	endtask

	// register extremes: zero and full gain, frozen and fastest smoothers,
	// gate fully open and fully closed
	task automatic test_config_extremes();
		write_reg(REG_GATE, THR_W'(0));
		write_reg(REG_GAIN, GAIN_W'(0));
		send_beat(32'sh7FFFFFFF);
		drain();
		write_reg(REG_GAIN, GAIN_W'(65535));
		send_beat(32'sh7FFFFFFF);
		send_beat(32'sh80000000);
		drain();
		write_reg(REG_ALPHA1, ALPHA_W'(0));
		send_beat(32'sh7FFFFFFF);
		drain();
		write_reg(REG_ALPHA1, ALPHA_W'(65535));
		write_reg(REG_ALPHA2, ALPHA_W'(0));
		send_beat(32'sh80000000);
		drain();
		write_reg(REG_ALPHA2, ALPHA_W'(65535));
		write_reg(REG_GATE, THR_W'(4194303));
		send_beat(32'sh7FFFFFFF);
		send_beat(32'sh80000000);
		drain();
	endtask

	// 16-bit registers written with junk in the upper data bits
	task automatic test_register_masking();
		write_reg(REG_GATE, THR_W'(20));
		write_reg(REG_GAIN, {6'h3F, 16'd4096});
		write_reg(REG_ALPHA1, {6'h2A, 16'd30000});
		write_reg(REG_ALPHA2, {6'h15, 16'd40000});
		send_beat(word_for_sample(50000));
		send_beat(word_for_sample(-70000));
		drain();
	endtask

	// long receiver hold-off while the sender keeps offering, so the block
	// fills and stalls its input
	task automatic test_backpressure();
		sender_gaps = 1'b0;
		hold_len    = 300;
		repeat (40)
			send_beat($urandom);
		drain();
	endtask

	// random phases, each under its own register setting
	task automatic test_random_phases();
		int               r;
		longint           x;
		longint           edge_x;
		logic [CFG_W-1:0] junk;
		for (int phase = 0; phase < 10; phase++) begin
			// gain
			junk = CFG_W'($urandom);
			r = $urandom_range(0, 4);
			case (r)
				0: junk[GAIN_W-1:0] = 16'd0;
				1: junk[GAIN_W-1:0] = 16'hFFFF;
				2: junk[GAIN_W-1:0] = 16'd4096;
				default: junk[GAIN_W-1:0] = GAIN_W'($urandom);
			endcase
			write_reg(REG_GAIN, junk);
			// gate threshold
			r = $urandom_range(0, 4);
			case (r)
				0: write_reg(REG_GATE, THR_W'(0));
				1: write_reg(REG_GATE, THR_W'(4194303));
				2: write_reg(REG_GATE, THR_W'($urandom));
				default: write_reg(REG_GATE, THR_W'($urandom_range(1, 200000)));
			endcase
			// smoother coefficients
			junk = CFG_W'($urandom);
			r = $urandom_range(0, 3);
			junk[ALPHA_W-1:0] = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : ALPHA_W'($urandom);
			write_reg(REG_ALPHA1, junk);
			junk = CFG_W'($urandom);
			r = $urandom_range(0, 3);
			junk[ALPHA_W-1:0] = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : ALPHA_W'($urandom);
			write_reg(REG_ALPHA2, junk);

			// some phases run back to back on the sender side, others on the receiver side
			sender_gaps = (phase % 3) != 1;
			sink_gaps   = (phase % 4) != 2;

			for (int n = 0; n < 100; n++) begin
				r = $urandom_range(0, 9);
				if (r < 6) begin
					send_beat($urandom);
				end else if (r < 9 && cur_gain != 0) begin
					// samples that land on or next to the gate threshold
					edge_x = (longint'(cur_threshold) * 4096) / cur_gain;
					x = edge_x + $urandom_range(0, 4) - 2;
					if (x > 131071)
						x = 131071;
					if (x < 0)
						x = 0;
					if ($urandom_range(0, 1))
						x = -x;
					send_beat(word_for_sample(x));
				end else begin
					r = $urandom_range(0, 3);
					case (r)
						0: send_beat(32'sh7FFFFFFF);
						1: send_beat(32'sh80000000);
						2: send_beat(word_for_sample($urandom_range(0, 3) - 2));
						default: send_beat(32'sh00000000);
					endcase
				end
				// now and then the sender waits for every result first
				if ($urandom_range(0, 49) == 0)
					drain();
			end
			drain();
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_GAIN;
		cfg_data       = '0;
		in_valid       = 1'b0;
		raw_word       = '0;
		mismatch_count = 0;
		result_count   = 0;
		sender_gaps    = 1'b1;
		sink_gaps      = 1'b1;
		hold_len       = 0;
		cur_gain       = GAIN_RST;
		cur_threshold  = THR_RST;
		cur_alpha1     = ALPHA1_RST;
		cur_alpha2     = ALPHA2_RST;
		lvl_first      = 0;
		lvl_second     = 0;

		repeat (RESET_CYC) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_reset_defaults();
		test_gate_boundary();
		test_config_extremes();
		test_register_masking();
		test_backpressure();
		test_random_phases();

		drain();
		if (mismatch_count == 0 && expected_levels.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
